// ===== sv/wwtg_pkg.sv =====
// wwtg_pkg: shared constants, register codes and control types of the window tap gather
// no dependencies; every other file but wwtg_ram refers to it by scoped names

package wwtg_pkg;

    localparam int MASK_ROWS  = 3;
    localparam int MASK_COLS  = 3;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int TAP_N    = 9;
    localparam int TAP_W    = 4;
    localparam int POS_W    = 6;
    localparam int RED_W    = 8;
    localparam int WEIGHT_W = 8;
    localparam int VALUE_W  = 16;
    localparam int DIM_W    = 7;
    localparam int EN_W     = 9;
    localparam int ROW_W    = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int SC_W     = ((DIM_BITS > POS_W + 1) ? DIM_BITS : POS_W + 1) + 1;

    localparam int DX_MIN = -(MASK_ROWS / 2);
    localparam int DX_MAX = MASK_ROWS - 1 - (MASK_ROWS / 2);
    localparam int DY_MIN = -(MASK_COLS / 2);
    localparam int DY_MAX = MASK_COLS - 1 - (MASK_COLS / 2);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_ENABLES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_ROW0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_ROW1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_ROW2 = 3'd5;

    localparam logic [EN_W-1:0]  TAP_EN_RST = 9'd16;
    localparam logic [ROW_W-1:0] WROW0_RST  = 24'd0;
    localparam logic [ROW_W-1:0] WROW1_RST  = 24'd256;
    localparam logic [ROW_W-1:0] WROW2_RST  = 24'd0;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic load_query;
        logic write_pixel;
        logic issue;
    } t_dp_cmd;

    typedef struct packed {
        logic can_issue;
        logic mask_any;
        logic mask_single;
    } t_dp_sts;

endpackage

// ===== sv/wwtg_if.sv =====
// wwtg_in_if / wwtg_out_if: valid-ready channels for input items and result items
// depends on wwtg_pkg for field widths

interface wwtg_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [wwtg_pkg::POS_W-1:0]   pos_x;
    logic [wwtg_pkg::POS_W-1:0]   pos_y;
    logic [wwtg_pkg::RED_W-1:0]   red_value;

    modport source (output valid, output kind, output pos_x, output pos_y,
                    output red_value, input ready);
    modport sink   (input valid, input kind, input pos_x, input pos_y,
                    input red_value, output ready);
endinterface

interface wwtg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wwtg_pkg::VALUE_W-1:0] weighted_value;
    logic [wwtg_pkg::TAP_W-1:0]          tap_index;
    logic                                last;

    modport source (output valid, output weighted_value, output tap_index,
                    output last, input ready);
    modport sink   (input valid, input weighted_value, input tap_index,
                    input last, output ready);
endinterface

// ===== sv/wwtg_ram.sv =====
// wwtg_ram: generic single write port, single read port ram with registered read data
// no dependencies

module wwtg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wwtg_ctrl.sv =====
// wwtg_ctrl: item acceptance and tap issue sequencing
// depends on wwtg_pkg for command and status types

module wwtg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    output logic              o_ready,
    input  wwtg_pkg::t_dp_sts i_sts,
    output wwtg_pkg::t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd.load_query  = accept && (i_kind == wwtg_pkg::KIND_QUERY);
        o_cmd.write_pixel = accept && (i_kind == wwtg_pkg::KIND_WRITE);
        o_cmd.issue       = (r_state == ST_SCAN) && i_sts.mask_any && i_sts.can_issue;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load_query) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.mask_any || (o_cmd.issue && i_sts.mask_single)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/wwtg_dp.sv =====
// wwtg_dp: configuration registers, tap qualify mask, frame store, multiply and output stage
// depends on wwtg_pkg and wwtg_ram

module wwtg_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [wwtg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [wwtg_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wwtg_pkg::t_dp_cmd                     i_cmd,
    output wwtg_pkg::t_dp_sts                     o_sts,
    input  logic [wwtg_pkg::POS_W-1:0]            i_pos_x,
    input  logic [wwtg_pkg::POS_W-1:0]            i_pos_y,
    input  logic [wwtg_pkg::RED_W-1:0]            i_red_value,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [wwtg_pkg::VALUE_W-1:0]   o_out_value,
    output logic [wwtg_pkg::TAP_W-1:0]            o_out_tap,
    output logic                                  o_out_last
);

    localparam int SC_W   = wwtg_pkg::SC_W;
    localparam int ADDR_W = wwtg_pkg::ADDR_W;
    localparam int TAP_N  = wwtg_pkg::TAP_N;

    // configuration
    logic [wwtg_pkg::DIM_W-1:0] r_img_w;
    logic [wwtg_pkg::DIM_W-1:0] r_img_h;
    logic [wwtg_pkg::EN_W-1:0]  r_tap_en;
    logic [wwtg_pkg::ROW_W-1:0] r_wrow0;
    logic [wwtg_pkg::ROW_W-1:0] r_wrow1;
    logic [wwtg_pkg::ROW_W-1:0] r_wrow2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= '0;
            r_img_h  <= '0;
            r_tap_en <= wwtg_pkg::TAP_EN_RST;
            r_wrow0  <= wwtg_pkg::WROW0_RST;
            r_wrow1  <= wwtg_pkg::WROW1_RST;
            r_wrow2  <= wwtg_pkg::WROW2_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wwtg_pkg::CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[wwtg_pkg::DIM_W-1:0];
                wwtg_pkg::CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[wwtg_pkg::DIM_W-1:0];
                wwtg_pkg::CFG_TAP_ENABLES:  r_tap_en <= i_cfg_data[wwtg_pkg::EN_W-1:0];
                wwtg_pkg::CFG_WEIGHTS_ROW0: r_wrow0  <= i_cfg_data[wwtg_pkg::ROW_W-1:0];
                wwtg_pkg::CFG_WEIGHTS_ROW1: r_wrow1  <= i_cfg_data[wwtg_pkg::ROW_W-1:0];
                wwtg_pkg::CFG_WEIGHTS_ROW2: r_wrow2  <= i_cfg_data[wwtg_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // image size limited to the store
    logic signed [SC_W-1:0] w_lim;
    logic signed [SC_W-1:0] h_lim;

    assign w_lim = (int'(r_img_w) > wwtg_pkg::MAX_WIDTH) ?
                   SC_W'(wwtg_pkg::MAX_WIDTH) : SC_W'(r_img_w);
    assign h_lim = (int'(r_img_h) > wwtg_pkg::MAX_HEIGHT) ?
                   SC_W'(wwtg_pkg::MAX_HEIGHT) : SC_W'(r_img_h);

    // per-tap qualify from the incoming centre, address from the held centre, weight from the weight rows
    logic [wwtg_pkg::POS_W-1:0]    r_cx;
    logic [wwtg_pkg::POS_W-1:0]    r_cy;
    logic [TAP_N-1:0]              r_qmask;
    logic [TAP_N-1:0]              qual;
    logic signed [SC_W-1:0]        q_tx [TAP_N];
    logic signed [SC_W-1:0]        q_ty [TAP_N];
    logic signed [SC_W-1:0]        h_tx [TAP_N];
    logic signed [SC_W-1:0]        h_ty [TAP_N];
    logic [ADDR_W-1:0]             tap_addr [TAP_N];
    logic [wwtg_pkg::WEIGHT_W-1:0] tap_wt [TAP_N];

    always_comb begin
        for (int xo = 0; xo < 3; xo++) begin
            for (int yo = 0; yo < 3; yo++) begin
                q_tx[xo*3+yo] = SC_W'(int'(i_pos_x) + xo - 1);
                q_ty[xo*3+yo] = SC_W'(int'(i_pos_y) + yo - 1);
                h_tx[xo*3+yo] = SC_W'(int'(r_cx) + xo - 1);
                h_ty[xo*3+yo] = SC_W'(int'(r_cy) + yo - 1);
                qual[xo*3+yo] = r_tap_en[xo*3+yo]
                    && (xo - 1 >= wwtg_pkg::DX_MIN) && (xo - 1 <= wwtg_pkg::DX_MAX)
                    && (yo - 1 >= wwtg_pkg::DY_MIN) && (yo - 1 <= wwtg_pkg::DY_MAX)
                    && (q_tx[xo*3+yo] >= 0) && (q_tx[xo*3+yo] < w_lim)
                    && (q_ty[xo*3+yo] >= 0) && (q_ty[xo*3+yo] < h_lim);
                tap_addr[xo*3+yo] = ADDR_W'(int'(h_ty[xo*3+yo]) * wwtg_pkg::MAX_WIDTH
                                            + int'(h_tx[xo*3+yo]));
                if (xo == 0) begin
                    tap_wt[xo*3+yo] = r_wrow0[8*yo +: 8];
                end else if (xo == 1) begin
                    tap_wt[xo*3+yo] = r_wrow1[8*yo +: 8];
                end else begin
                    tap_wt[xo*3+yo] = r_wrow2[8*yo +: 8];
                end
            end
        end
    end

    // lowest pending tap goes next
    logic [wwtg_pkg::TAP_W-1:0] pick;
    logic [TAP_N-1:0]           rest;

    always_comb begin
        pick = '0;
        for (int i = TAP_N - 1; i >= 0; i--) begin
            if (r_qmask[i]) begin
                pick = wwtg_pkg::TAP_W'(i);
            end
        end
    end

    assign rest = r_qmask & (r_qmask - TAP_N'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmask <= '0;
        end else if (i_cmd.load_query) begin
            r_qmask <= qual;
        end else if (i_cmd.issue) begin
            r_qmask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_cx <= i_pos_x;
            r_cy <= i_pos_y;
        end
    end

    // frame store
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [wwtg_pkg::RED_W-1:0] rd_data;

    assign wr_en   = i_cmd.write_pixel && (int'(i_pos_x) < wwtg_pkg::MAX_WIDTH)
                     && (int'(i_pos_y) < wwtg_pkg::MAX_HEIGHT);
    assign wr_addr = ADDR_W'(int'(i_pos_y) * wwtg_pkg::MAX_WIDTH + int'(i_pos_x));

    wwtg_ram #(
        .WIDTH (wwtg_pkg::RED_W),
        .DEPTH (wwtg_pkg::STORE_DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_red_value),
        .i_re    (i_cmd.issue),
        .i_raddr (tap_addr[pick]),
        .o_rdata (rd_data)
    );

    // read stage and output register
    logic                                r_s1_valid;
    logic signed [wwtg_pkg::WEIGHT_W-1:0] r_s1_wt;
    logic [wwtg_pkg::TAP_W-1:0]          r_s1_tap;
    logic                                r_s1_last;
    logic                                r_o_valid;
    logic signed [wwtg_pkg::VALUE_W-1:0] r_o_value;
    logic [wwtg_pkg::TAP_W-1:0]          r_o_tap;
    logic                                r_o_last;
    logic                                s1_move;
    logic signed [wwtg_pkg::WEIGHT_W+wwtg_pkg::RED_W:0] prod;

    assign s1_move = r_s1_valid && (!r_o_valid || i_out_ready);
    assign prod    = r_s1_wt * $signed({1'b0, rd_data});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_wt   <= tap_wt[pick];
            r_s1_tap  <= pick;
            r_s1_last <= (rest == '0);
        end
        if (s1_move) begin
            r_o_value <= prod[wwtg_pkg::VALUE_W-1:0];
            r_o_tap   <= r_s1_tap;
            r_o_last  <= r_s1_last;
        end
    end

    always_comb begin
        o_sts.can_issue   = !r_s1_valid || s1_move;
        o_sts.mask_any    = (r_qmask != '0);
        o_sts.mask_single = (rest == '0);
    end

    assign o_out_valid = r_o_valid;
    assign o_out_value = r_o_value;
    assign o_out_tap   = r_o_tap;
    assign o_out_last  = r_o_last;

endmodule

// ===== sv/weighted_window_tap_gather.sv =====
// weighted_window_tap_gather: top level joining the controller, the datapath and the channels
// depends on wwtg_pkg, wwtg_if, wwtg_ctrl, wwtg_dp

// A write transaction stores one red pixel into the 64x64 frame store in the cycle it is
// accepted and leaves the input ready for the next transaction. A query transaction
// latches the qualify mask of its enabled in-image taps in the accept cycle, then issues
// its taps through the single frame store read port, one per cycle unless the output
// stalls, and holds the input until the last is issued (or the empty mask is seen). Each
// result passes through the read stage and the output register after its tap is issued,
// in ascending tap order, the final one with last set; a stalled output holds back
// further reads but not the acceptance of the next transaction once the taps of a query
// are issued. Pixels must be written before they are read; the store has no reset.

module weighted_window_tap_gather (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wwtg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wwtg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wwtg_in_if.sink                           i_item,
    wwtg_out_if.source                        o_result
);

    wwtg_pkg::t_dp_cmd cmd;
    wwtg_pkg::t_dp_sts sts;

    wwtg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_kind  (i_item.kind),
        .o_ready (i_item.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wwtg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pos_x     (i_item.pos_x),
        .i_pos_y     (i_item.pos_y),
        .i_red_value (i_item.red_value),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out_value (o_result.weighted_value),
        .o_out_tap   (o_result.tap_index),
        .o_out_last  (o_result.last)
    );

`ifndef SYNTH
    a_issue_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> sts.can_issue)
        else $error("tap issued while read stage is blocked");

    a_no_issue_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |-> !cmd.issue)
        else $error("transaction accepted during tap issue");

    a_last_tap_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.issue && sts.mask_single) |=> i_item.ready)
        else $error("input not released after the final tap");
`endif

endmodule
